// ===== rtl/plane_set_box_classifier_macros.svh =====
// Assertion macros shared by the plane set box classifier RTL.
`ifndef PLANE_SET_BOX_CLASSIFIER_MACROS_SVH
`define PLANE_SET_BOX_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PSBC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psbc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PSBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psbc: next-cycle check failed");

`endif

// ===== rtl/psbc_pkg.sv =====
// Types, constants and helpers shared by the plane set box classifier.
package psbc_pkg;

  localparam int PLANE_W    = 64;
  localparam int NORM_W     = 16;
  localparam int Q14_SHIFT  = 14;
  localparam int COUNT_W    = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int OUT_W      = 8;
  localparam int USER_W     = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_COUNT = 3'd0;

  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_BOX   = 1'b1;

  typedef logic [PLANE_W-1:0] plane_t;

  typedef enum logic [1:0] {
    VERDICT_IN   = 2'd0,
    VERDICT_OUT  = 2'd1,
    VERDICT_PART = 2'd2
  } verdict_t;

  // Running result of an item as it moves down the cell row.
  typedef struct packed {
    logic invalid;
    logic outside;
    logic part;
  } cull_flags_t;

  function automatic verdict_t flags_to_verdict(cull_flags_t f);
    verdict_t v;
    if (f.invalid) begin
      v = VERDICT_PART;
    end else if (f.outside) begin
      v = VERDICT_OUT;
    end else if (f.part) begin
      v = VERDICT_PART;
    end else begin
      v = VERDICT_IN;
    end
    return v;
  endfunction

endpackage

// ===== rtl/psbc_cfg.sv =====
// Plane count and plane registers of the classifier.
module psbc_cfg #(
  parameter int MAX_PLANES = 6
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_we,
  input  logic [psbc_pkg::CFG_ADDR_W-1:0]               cfg_addr,
  input  logic [psbc_pkg::PLANE_W-1:0]                  cfg_data,
  output logic [MAX_PLANES-1:0][psbc_pkg::PLANE_W-1:0]  planes,
  output logic [psbc_pkg::COUNT_W-1:0]                  active_count
);
  import psbc_pkg::*;

  logic [COUNT_W-1:0] plane_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count <= '0;
      planes      <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_IDX_COUNT) begin
        plane_count <= cfg_data[COUNT_W-1:0];
      end
      for (int k = 0; k < MAX_PLANES; k++) begin
        if (cfg_addr == CFG_ADDR_W'(k + 1)) begin
          planes[k] <= cfg_data;
        end
      end
    end
  end

  // Clamp the count to the planes that exist.
  assign active_count = (plane_count > COUNT_W'(MAX_PLANES)) ? COUNT_W'(MAX_PLANES)
                                                            : plane_count;

endmodule

// ===== rtl/psbc_cell.sv =====
// One plane cell: multiply stage, then sum and sign stage, with handshake.
`include "plane_set_box_classifier_macros.svh"

module psbc_cell #(
  parameter int CW = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  psbc_pkg::plane_t      plane,
  input  logic                  enable,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3*CW-1:0]       in_lo,
  input  logic [3*CW-1:0]       in_hi,
  input  psbc_pkg::cull_flags_t in_flags,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3*CW-1:0]       out_lo,
  output logic [3*CW-1:0]       out_hi,
  output psbc_pkg::cull_flags_t out_flags
);
  import psbc_pkg::*;

  localparam int PROD_W   = NORM_W + CW;
  localparam int D_TERM_W = NORM_W + Q14_SHIFT;
  localparam int ACC_W    = ((PROD_W > D_TERM_W) ? PROD_W : D_TERM_W) + 2;

  // multiply stage
  logic                     a_valid;
  logic [3*CW-1:0]          a_lo;
  logic [3*CW-1:0]          a_hi;
  cull_flags_t              a_flags;
  logic signed [NORM_W-1:0] a_d;
  logic signed [PROD_W-1:0] a_pmin [3];
  logic signed [PROD_W-1:0] a_pmax [3];
  logic                     a_ready;

  // sum stage
  logic            b_valid;
  logic [3*CW-1:0] b_lo;
  logic [3*CW-1:0] b_hi;
  cull_flags_t     b_flags;
  logic            b_ready;

  logic signed [PROD_W-1:0] pmin_next [3];
  logic signed [PROD_W-1:0] pmax_next [3];
  logic signed [ACC_W-1:0]  sum_min;
  logic signed [ACC_W-1:0]  sum_max;
  cull_flags_t              flags_next;

  assign b_ready  = !b_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // Per axis, a nonnegative normal gets its smallest term from the smaller
  // of the two coordinates and its largest from the larger one; a negative
  // normal the other way round. Swapped bounds need no special handling.
  always_comb begin
    logic signed [NORM_W-1:0] n;
    logic signed [CW-1:0]     c_lo;
    logic signed [CW-1:0]     c_hi;
    logic signed [CW-1:0]     c_small;
    logic signed [CW-1:0]     c_big;
    for (int j = 0; j < 3; j++) begin
      n    = plane[j*NORM_W +: NORM_W];
      c_lo = in_lo[j*CW +: CW];
      c_hi = in_hi[j*CW +: CW];
      if (c_lo > c_hi) begin
        c_small = c_hi;
        c_big   = c_lo;
      end else begin
        c_small = c_lo;
        c_big   = c_hi;
      end
      if (n[NORM_W-1]) begin
        pmin_next[j] = PROD_W'(n) * PROD_W'(c_big);
        pmax_next[j] = PROD_W'(n) * PROD_W'(c_small);
      end else begin
        pmin_next[j] = PROD_W'(n) * PROD_W'(c_small);
        pmax_next[j] = PROD_W'(n) * PROD_W'(c_big);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_lo    <= in_lo;
      a_hi    <= in_hi;
      a_flags <= in_flags;
      a_d     <= plane[3*NORM_W +: NORM_W];
      a_pmin  <= pmin_next;
      a_pmax  <= pmax_next;
    end
  end

  always_comb begin
    sum_min = ACC_W'(a_pmin[0]) + ACC_W'(a_pmin[1]) + ACC_W'(a_pmin[2])
            + (ACC_W'(a_d) <<< Q14_SHIFT);
    sum_max = ACC_W'(a_pmax[0]) + ACC_W'(a_pmax[1]) + ACC_W'(a_pmax[2])
            + (ACC_W'(a_d) <<< Q14_SHIFT);
    flags_next = a_flags;
    // all corners below the plane: outside; some below: partly inside
    flags_next.outside = a_flags.outside | (enable & sum_max[ACC_W-1]);
    flags_next.part    = a_flags.part    | (enable & sum_min[ACC_W-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_lo    <= a_lo;
      b_hi    <= a_hi;
      b_flags <= flags_next;
    end
  end

  assign out_valid = b_valid;
  assign out_lo    = b_lo;
  assign out_hi    = b_hi;
  assign out_flags = b_flags;

  `PSBC_ASSERT_NEXT(a_cell_take, clk, rst, in_valid && in_ready, a_valid)
  `PSBC_ASSERT_NEXT(a_cell_move, clk, rst, a_valid && b_ready, b_valid)
  `PSBC_ASSERT_NEXT(a_cell_hold, clk, rst, b_valid && !out_ready, b_valid && $stable(b_flags))

endmodule

// ===== rtl/plane_set_box_classifier.sv =====
// Top level of the plane set box classifier: config, cell row, output register.
`include "plane_set_box_classifier_macros.svh"

// Classifies a point or an axis-aligned box against up to MAX_PLANES planes
// and returns inside, outside or partly inside. One item is accepted per
// clock unless a stalled result has filled every stage; each item walks a
// row of MAX_PLANES plane cells, two register stages per cell (products,
// then sum and sign), and then the output register that holds its verdict.
// A stalled result holds the row back stage by stage, and input is refused
// only when every stage is full. Each cell finds the lowest and highest
// corner distance from the normal signs and the smaller and larger
// coordinate per axis, which stands for all eight corners.
// Configuration writes take effect at once and belong between items.
module plane_set_box_classifier #(
  parameter int MAX_PLANES  = 6,
  parameter int COORD_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [psbc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [psbc_pkg::PLANE_W-1:0]           cfg_data,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z, zero fill
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  // cmd, box_valid
  input  logic [psbc_pkg::USER_W-1:0]            s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // verdict, zero fill
  output logic [psbc_pkg::OUT_W-1:0]             m_axis_tdata
);
  import psbc_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic [MAX_PLANES-1:0][PLANE_W-1:0] planes;
  logic [COUNT_W-1:0]                 active_count;

  logic [MAX_PLANES:0]               ch_valid;
  logic [MAX_PLANES:0]               ch_ready;
  logic [MAX_PLANES:0][3*CW-1:0]     ch_lo;
  logic [MAX_PLANES:0][3*CW-1:0]     ch_hi;
  cull_flags_t                       ch_flags [MAX_PLANES+1];

  logic     cmd;
  logic     box_valid;
  logic     out_ready;
  verdict_t verdict;

  psbc_cfg #(
    .MAX_PLANES (MAX_PLANES)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .planes       (planes),
    .active_count (active_count)
  );

  assign cmd       = s_axis_tuser[0];
  assign box_valid = s_axis_tuser[1];

  // A point enters as a box whose max equals its min.
  assign ch_valid[0]         = s_axis_tvalid;
  assign s_axis_tready       = ch_ready[0];
  assign ch_lo[0]            = s_axis_tdata[3*CW-1:0];
  assign ch_hi[0]            = (cmd == CMD_BOX) ? s_axis_tdata[6*CW-1:3*CW]
                                                : s_axis_tdata[3*CW-1:0];
  assign ch_flags[0].invalid = (cmd == CMD_BOX) && !box_valid;
  assign ch_flags[0].outside = 1'b0;
  assign ch_flags[0].part    = 1'b0;

  for (genvar k = 0; k < MAX_PLANES; k++) begin : g_cell
    psbc_cell #(
      .CW (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .plane     (planes[k]),
      .enable    (active_count > COUNT_W'(k)),
      .in_valid  (ch_valid[k]),
      .in_ready  (ch_ready[k]),
      .in_lo     (ch_lo[k]),
      .in_hi     (ch_hi[k]),
      .in_flags  (ch_flags[k]),
      .out_valid (ch_valid[k+1]),
      .out_ready (ch_ready[k+1]),
      .out_lo    (ch_lo[k+1]),
      .out_hi    (ch_hi[k+1]),
      .out_flags (ch_flags[k+1])
    );
  end

  assign out_ready            = !m_axis_tvalid || m_axis_tready;
  assign ch_ready[MAX_PLANES] = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= ch_valid[MAX_PLANES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && ch_valid[MAX_PLANES]) begin
      verdict <= flags_to_verdict(ch_flags[MAX_PLANES]);
    end
  end

  assign m_axis_tdata = OUT_W'(verdict);

  `PSBC_ASSERT_IMPLY(a_stall_only_full, clk, rst, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  `PSBC_ASSERT_NEXT(a_out_load, clk, rst, ch_valid[MAX_PLANES] && out_ready, m_axis_tvalid)
  `PSBC_ASSERT_NEXT(a_out_drain, clk, rst, m_axis_tvalid && m_axis_tready && !ch_valid[MAX_PLANES], !m_axis_tvalid)

endmodule
